// File: rtl/core/gtp_pkg.sv
package gtp_pkg;

   // Stage limit and datapath widths of the two CORDIC units.
   localparam int MAX_STAGES = 24;
   localparam int VW = 53;
   localparam int ZW = 35;
   localparam int RW = 48;

   // Angle constants: 2^-30 rad for the CORDIC angle path, Q3.13 elsewhere.
   localparam logic signed [ZW-1:0] HALF_PI_A30 = 35'sd1686629713;
   localparam logic signed [ZW-1:0] PI_A30 = 35'sd3373259426;
   localparam logic [29:0] INV_K_Q30 = 30'd652032874;
   localparam logic signed [17:0] PI_Q13 = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
   localparam logic signed [17:0] NINTH_PI_Q13 = 18'sd2860;

   // Request modes.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_STEP = 2'd1;

   // Status codes.
   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_RUN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_TERM = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_GOAL_X = 3'd0;
   localparam logic [2:0] REG_GOAL_Y = 3'd1;
   localparam logic [2:0] REG_GOAL_HEADING = 3'd2;
   localparam logic [2:0] REG_DIST_TOL = 3'd3;
   localparam logic [2:0] REG_HEAD_TOL = 3'd4;
   localparam logic [2:0] REG_SPEED_LIMIT = 3'd5;
   localparam logic [2:0] REG_TURN_LIMIT = 3'd6;
   localparam logic [2:0] REG_FLAGS = 3'd7;

   // Flag bit positions.
   localparam int FLAG_OMNI = 0;
   localparam int FLAG_SIMPLE = 1;
   localparam int FLAG_REL = 2;

   typedef struct packed {
      logic signed [15:0] goal_heading;
      logic [30:0] dist_tol;
      logic [14:0] head_tol;
      logic [14:0] speed_limit;
      logic [14:0] turn_limit;
      logic [2:0] flags;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic signed [15:0] heading;
   } vec_side_type;

   typedef struct packed {
      logic signed [15:0] vx_plain;
      logic signed [15:0] turn;
      logic [1:0] status;
      logic use_rot;
   } rot_side_type;

   // Arctangent of 2^-i in 2^-30 rad.
   function automatic logic [29:0] atan_a30(input int i);
      logic [29:0] a;
      case (i)
         0: a = 30'd843314857;
         1: a = 30'd497837829;
         2: a = 30'd263043837;
         3: a = 30'd133525159;
         4: a = 30'd67021687;
         5: a = 30'd33543516;
         6: a = 30'd16775851;
         7: a = 30'd8388437;
         8: a = 30'd4194283;
         9: a = 30'd2097149;
         10: a = 30'd1048576;
         11: a = 30'd524288;
         12: a = 30'd262144;
         13: a = 30'd131072;
         14: a = 30'd65536;
         15: a = 30'd32768;
         16: a = 30'd16384;
         17: a = 30'd8192;
         18: a = 30'd4096;
         19: a = 30'd2048;
         20: a = 30'd1024;
         21: a = 30'd512;
         22: a = 30'd256;
         23: a = 30'd128;
         default: a = 30'd0;
      endcase
      return a;
   endfunction

   // Reduce a heading difference below two turns into [-pi, pi].
   function automatic logic signed [15:0] wrap_q13(input logic signed [17:0] v);
      logic signed [17:0] t;
      t = v;
      if (t >= TWO_PI_Q13) t = t - TWO_PI_Q13;
      else if (t <= -TWO_PI_Q13) t = t + TWO_PI_Q13;
      if (t > PI_Q13) t = t - TWO_PI_Q13;
      else if (t < -PI_Q13) t = t + TWO_PI_Q13;
      return t[15:0];
   endfunction

endpackage

// File: rtl/core/gtp_if.sv
interface gtp_req_if;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic signed [15:0] pose_heading;
   modport source (output valid, mode, pose_x, pose_y, pose_heading, input ready);
   modport sink (input valid, mode, pose_x, pose_y, pose_heading, output ready);
endinterface

interface gtp_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] velocity_x;
   logic signed [15:0] velocity_y;
   logic signed [15:0] turn_rate;
   logic [1:0] status;
   modport source (output valid, velocity_x, velocity_y, turn_rate, status, input ready);
   modport sink (input valid, velocity_x, velocity_y, turn_rate, status, output ready);
endinterface

interface gtp_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/gtp_vec_cordic.sv
module gtp_vec_cordic
   import gtp_pkg::*;
#(
   parameter int STAGES = 16
) (
   input logic clock,
   input logic reset,
   input logic en,
   input logic in_valid,
   input logic signed [33:0] dx,
   input logic signed [33:0] dy,
   input vec_side_type side_in,
   output logic out_valid,
   output logic [35:0] r,
   output logic signed [17:0] ang,
   output vec_side_type side_out
);

   // Entry register.
   logic valid0_ff;
   logic signed [33:0] dx0_ff, dy0_ff;
   logic zero0_ff;
   vec_side_type side0_ff;

   always_ff @(posedge clock) begin
      if (reset) valid0_ff <= 1'b0;
      else if (en) valid0_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx0_ff <= dx;
         dy0_ff <= dy;
         zero0_ff <= (dx == 34'sd0) && (dy == 34'sd0);
         side0_ff <= side_in;
      end
   end

   // Quadrant correction into the right half plane.
   logic signed [VW-1:0] xs, ys, xp_in, yp_in;
   logic signed [ZW-1:0] zp_in;

   always_comb begin
      xs = VW'(dx0_ff) <<< 16;
      ys = VW'(dy0_ff) <<< 16;
      xp_in = xs;
      yp_in = ys;
      zp_in = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            xp_in = ys;
            yp_in = -xs;
            zp_in = HALF_PI_A30;
         end else begin
            xp_in = -ys;
            yp_in = xs;
            zp_in = -HALF_PI_A30;
         end
      end
   end

   logic signed [VW-1:0] x_ff [STAGES+1];
   logic signed [VW-1:0] y_ff [STAGES+1];
   logic signed [ZW-1:0] z_ff [STAGES+1];
   logic valid_ff [STAGES+1];
   logic zero_ff [STAGES+1];
   vec_side_type side_ff [STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (en) valid_ff[0] <= valid0_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= xp_in;
         y_ff[0] <= yp_in;
         z_ff[0] <= zp_in;
         zero_ff[0] <= zero0_ff;
         side_ff[0] <= side0_ff;
      end
   end

   // One micro-rotation per stage, driving y toward zero.
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [ZW-1:0] atan_step;
      assign atan_step = $signed({{(ZW-30){1'b0}}, atan_a30(i)});

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else if (en) valid_ff[i+1] <= valid_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_step;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_step;
            end
            zero_ff[i+1] <= zero_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Gain correction: split the magnitude so each multiplier operand is at most 32 bits wide.
   logic [VW-2:0] mag;
   logic signed [ZW-1:0] z_round;
   assign mag = (x_ff[STAGES] < 0) ? '0 : x_ff[STAGES][VW-2:0];
   assign z_round = z_ff[STAGES] + 35'sd65536;

   logic validm_ff, zerom_ff;
   logic [61:0] phi_ff;
   logic [49:0] plo_ff;
   logic signed [17:0] angm_ff;
   vec_side_type sidem_ff;

   always_ff @(posedge clock) begin
      if (reset) validm_ff <= 1'b0;
      else if (en) validm_ff <= valid_ff[STAGES];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff <= mag[VW-2:20] * INV_K_Q30;
         plo_ff <= mag[19:0] * INV_K_Q30;
         angm_ff <= z_round[ZW-1:17];
         zerom_ff <= zero_ff[STAGES];
         sidem_ff <= side_ff[STAGES];
      end
   end

   // Final sum and output register.
   logic [61:0] rsum;
   assign rsum = phi_ff + 62'(plo_ff >> 20);

   logic validr_ff;
   logic [35:0] r_ff;
   logic signed [17:0] ang_ff;
   vec_side_type sider_ff;

   always_ff @(posedge clock) begin
      if (reset) validr_ff <= 1'b0;
      else if (en) validr_ff <= validm_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= zerom_ff ? '0 : rsum[61:26];
         ang_ff <= zerom_ff ? '0 : angm_ff;
         sider_ff <= sidem_ff;
      end
   end

   assign out_valid = validr_ff;
   assign r = r_ff;
   assign ang = ang_ff;
   assign side_out = sider_ff;

endmodule

// File: rtl/core/gtp_law.sv
module gtp_law
   import gtp_pkg::*;
#(
   parameter int GAIN_DISTANCE_SIMPLE = 256,
   parameter int GAIN_ALPHA = 256,
   parameter int GAIN_DISTANCE_POLAR = 256,
   parameter int GAIN_BETA = 128
) (
   input logic clock,
   input logic reset,
   input logic en,
   input logic in_valid,
   input logic [35:0] r,
   input logic signed [17:0] ang,
   input vec_side_type side_in,
   input cfg_type cfg,
   output logic out_valid,
   output logic signed [15:0] speed,
   output logic signed [15:0] alpha_rot,
   output rot_side_type side_out
);

   localparam logic [15:0] GDS = 16'(GAIN_DISTANCE_SIMPLE);
   localparam logic [15:0] GDP = 16'(GAIN_DISTANCE_POLAR);
   localparam logic [15:0] GA = 16'(GAIN_ALPHA);
   localparam logic [15:0] GB = 16'(GAIN_BETA);

   logic simple, holo;
   assign simple = cfg.flags[FLAG_SIMPLE];
   assign holo = cfg.flags[FLAG_OMNI];

   // Stage 1: heading errors, wraps and threshold tests.
   logic signed [17:0] gh_ext, ph_ext, alpha_s_ext, alpha_p, beta_p;
   logic signed [15:0] herr, alpha_s, habs, aabs;

   always_comb begin
      gh_ext = {{2{cfg.goal_heading[15]}}, cfg.goal_heading};
      ph_ext = {{2{side_in.heading[15]}}, side_in.heading};
      herr = wrap_q13(gh_ext - ph_ext);
      alpha_s = wrap_q13(ang - ph_ext);
      alpha_s_ext = {{2{alpha_s[15]}}, alpha_s};
      alpha_p = alpha_s_ext - gh_ext;
      beta_p = -gh_ext - alpha_p;
      habs = (herr < 0) ? -herr : herr;
      aabs = (alpha_s < 0) ? -alpha_s : alpha_s;
   end

   logic valid1_ff, near1_ff, hok1_ff, turn1_ff, herr_pos1_ff, alpha_pos1_ff;
   logic [35:0] r1_ff;
   logic signed [17:0] alpha1_ff, beta1_ff;
   logic [1:0] mode1_ff;

   always_ff @(posedge clock) begin
      if (reset) valid1_ff <= 1'b0;
      else if (en) valid1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= r;
         alpha1_ff <= simple ? alpha_s_ext : alpha_p;
         beta1_ff <= beta_p;
         near1_ff <= r < {5'b0, cfg.dist_tol};
         hok1_ff <= $unsigned(habs) < {1'b0, cfg.head_tol};
         turn1_ff <= {{2{aabs[15]}}, aabs} > NINTH_PI_Q13;
         herr_pos1_ff <= herr > 0;
         alpha_pos1_ff <= alpha_s > 0;
         mode1_ff <= side_in.mode;
      end
   end

   // Stage 2: gain products.
   logic valid2_ff, near2_ff, hok2_ff, turn2_ff, herr_pos2_ff, alpha_pos2_ff;
   logic [51:0] pv2_ff;
   logic signed [34:0] pa2_ff, pb2_ff;
   logic [30:0] pm2_ff;
   logic signed [17:0] alpha2_ff;
   logic [1:0] mode2_ff;

   always_ff @(posedge clock) begin
      if (reset) valid2_ff <= 1'b0;
      else if (en) valid2_ff <= valid1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pv2_ff <= r1_ff * (simple ? GDS : GDP);
         pa2_ff <= $signed({1'b0, GA}) * alpha1_ff;
         pb2_ff <= $signed({1'b0, GB}) * beta1_ff;
         pm2_ff <= cfg.turn_limit * GA;
         alpha2_ff <= alpha1_ff;
         near2_ff <= near1_ff;
         hok2_ff <= hok1_ff;
         turn2_ff <= turn1_ff;
         herr_pos2_ff <= herr_pos1_ff;
         alpha_pos2_ff <= alpha_pos1_ff;
         mode2_ff <= mode1_ff;
      end
   end

   // Stage 3: clamping and command selection.
   logic [39:0] vraw;
   logic signed [15:0] v, wc, mag, trl;
   logic signed [35:0] wsum;
   logic signed [26:0] wsh, trl_ext;
   logic [22:0] mraw;
   rot_side_type side3;

   always_comb begin
      vraw = pv2_ff[51:12];
      v = (vraw > {25'b0, cfg.speed_limit}) ? {1'b0, cfg.speed_limit} : {1'b0, vraw[14:0]};
      wsum = simple ? 36'(pa2_ff) : (36'(pa2_ff) + 36'(pb2_ff));
      wsh = wsum[35:9];
      trl_ext = {12'b0, cfg.turn_limit};
      trl = {1'b0, cfg.turn_limit};
      if (wsh > trl_ext) wc = trl;
      else if (wsh < -trl_ext) wc = -trl;
      else wc = wsh[15:0];
      mraw = pm2_ff[30:8];
      mag = (mraw > 23'd32767) ? 16'sd32767 : {1'b0, mraw[14:0]};

      side3.vx_plain = '0;
      side3.turn = '0;
      side3.status = ST_RUN;
      side3.use_rot = 1'b0;
      case (mode2_ff)
         MODE_START: begin
            side3.status = ST_INIT;
         end
         MODE_STEP: begin
            if (simple) begin
               if (near2_ff) begin
                  if (hok2_ff) side3.status = ST_DONE;
                  else side3.turn = herr_pos2_ff ? mag : -mag;
               end else if (turn2_ff) begin
                  side3.turn = alpha_pos2_ff ? trl : -trl;
               end else begin
                  side3.turn = wc;
                  if (holo) side3.use_rot = 1'b1;
                  else side3.vx_plain = v;
               end
            end else begin
               if (near2_ff && hok2_ff) begin
                  side3.status = ST_DONE;
               end else begin
                  side3.turn = wc;
                  if (holo) side3.use_rot = 1'b1;
                  else side3.vx_plain = v;
               end
            end
         end
         default: begin
            side3.status = ST_TERM;
         end
      endcase
   end

   logic valid3_ff;
   logic signed [15:0] speed3_ff, alpha3_ff;
   rot_side_type side3_ff;

   always_ff @(posedge clock) begin
      if (reset) valid3_ff <= 1'b0;
      else if (en) valid3_ff <= valid2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         speed3_ff <= v;
         alpha3_ff <= wrap_q13(alpha2_ff);
         side3_ff <= side3;
      end
   end

   assign out_valid = valid3_ff;
   assign speed = speed3_ff;
   assign alpha_rot = alpha3_ff;
   assign side_out = side3_ff;

endmodule

// File: rtl/core/gtp_rot_cordic.sv
module gtp_rot_cordic
   import gtp_pkg::*;
#(
   parameter int STAGES = 16
) (
   input logic clock,
   input logic reset,
   input logic en,
   input logic in_valid,
   input logic signed [15:0] speed,
   input logic signed [15:0] alpha,
   input rot_side_type side_in,
   output logic out_valid,
   output logic signed [15:0] vx,
   output logic signed [15:0] vy,
   output rot_side_type side_out
);

   // Entry: prescale the speed by 1/K and move the angle to 2^-30 rad.
   logic valid0_ff;
   logic signed [RW-1:0] x0_ff;
   logic signed [ZW-1:0] z0_ff;
   rot_side_type side0_ff;
   logic signed [46:0] prod;

   assign prod = speed * $signed({1'b0, INV_K_Q30});

   always_ff @(posedge clock) begin
      if (reset) valid0_ff <= 1'b0;
      else if (en) valid0_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= RW'(prod);
         z0_ff <= ZW'(alpha) <<< 17;
         side0_ff <= side_in;
      end
   end

   logic signed [RW-1:0] x_ff [STAGES+1];
   logic signed [RW-1:0] y_ff [STAGES+1];
   logic signed [ZW-1:0] z_ff [STAGES+1];
   logic valid_ff [STAGES+1];
   rot_side_type side_ff [STAGES+1];

   // Fold angles beyond a quarter turn.
   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (en) valid_ff[0] <= valid0_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff[0] <= '0;
         side_ff[0] <= side0_ff;
         if (z0_ff > HALF_PI_A30) begin
            x_ff[0] <= -x0_ff;
            z_ff[0] <= z0_ff - PI_A30;
         end else if (z0_ff < -HALF_PI_A30) begin
            x_ff[0] <= -x0_ff;
            z_ff[0] <= z0_ff + PI_A30;
         end else begin
            x_ff[0] <= x0_ff;
            z_ff[0] <= z0_ff;
         end
      end
   end

   // One micro-rotation per stage, driving z toward zero.
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [ZW-1:0] atan_step;
      assign atan_step = $signed({{(ZW-30){1'b0}}, atan_a30(i)});

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else if (en) valid_ff[i+1] <= valid_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_step;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_step;
            end
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Round to Q4.12 and saturate.
   logic signed [RW-1:0] xr, yr;
   logic signed [17:0] xq, yq;

   always_comb begin
      xr = x_ff[STAGES] + (RW'(1) <<< 29);
      yr = y_ff[STAGES] + (RW'(1) <<< 29);
      xq = xr[RW-1:30];
      yq = yr[RW-1:30];
      if (xq > 18'sd32767) vx = 16'sd32767;
      else if (xq < -18'sd32768) vx = -16'sd32768;
      else vx = xq[15:0];
      if (yq > 18'sd32767) vy = 16'sd32767;
      else if (yq < -18'sd32768) vy = -16'sd32768;
      else vy = yq[15:0];
   end

   assign out_valid = valid_ff[STAGES];
   assign side_out = side_ff[STAGES];

endmodule

// File: rtl/core/go_to_pose_velocity_controller.sv
// Throughput: one request per cycle while the skid slot is empty; the vectoring and
// rotating CORDICs are fully pipelined, one micro-rotation per register stage.
// An output register with one skid slot catches the result in flight when the receiver
// stalls; requests are refused while the skid slot is full.
// Reset (synchronous, active high) clears the pipeline valids, the origin and the
// configuration registers to their default values.
module go_to_pose_velocity_controller
   import gtp_pkg::*;
#(
   parameter int GAIN_DISTANCE_SIMPLE = 256,
   parameter int GAIN_ALPHA = 256,
   parameter int GAIN_DISTANCE_POLAR = 256,
   parameter int GAIN_BETA = 128,
   parameter int CORDIC_STAGES = 16
) (
   input logic clock,
   input logic reset,
   gtp_req_if.sink req_ch,
   gtp_rsp_if.source rsp_ch,
   gtp_csr_if.sink csr_ch
);

   localparam int NST = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

   // Configuration registers.
   logic signed [31:0] goal_x_ff, goal_y_ff;
   cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         cfg_ff.goal_heading <= '0;
         cfg_ff.dist_tol <= 31'd6554;
         cfg_ff.head_tol <= 15'd820;
         cfg_ff.speed_limit <= 15'd4096;
         cfg_ff.turn_limit <= 15'd4096;
         cfg_ff.flags <= 3'd2;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_GOAL_X: goal_x_ff <= csr_ch.data;
            REG_GOAL_Y: goal_y_ff <= csr_ch.data;
            REG_GOAL_HEADING: cfg_ff.goal_heading <= csr_ch.data[15:0];
            REG_DIST_TOL: cfg_ff.dist_tol <= csr_ch.data[30:0];
            REG_HEAD_TOL: cfg_ff.head_tol <= csr_ch.data[14:0];
            REG_SPEED_LIMIT: cfg_ff.speed_limit <= csr_ch.data[14:0];
            REG_TURN_LIMIT: cfg_ff.turn_limit <= csr_ch.data[14:0];
            REG_FLAGS: cfg_ff.flags <= csr_ch.data[2:0];
            default: ;
         endcase
      end
   end

   // Pipeline advance and request accept.
   logic skid_valid_ff, rsp_valid_ff, en, accept;
   assign en = !skid_valid_ff;
   assign req_ch.ready = en;
   assign accept = req_ch.valid && req_ch.ready;

   // Origin capture on a start request.
   logic signed [31:0] origin_x_ff, origin_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (accept && (req_ch.mode == MODE_START)) begin
         origin_x_ff <= cfg_ff.flags[FLAG_REL] ? req_ch.pose_x : '0;
         origin_y_ff <= cfg_ff.flags[FLAG_REL] ? req_ch.pose_y : '0;
      end
   end

   // Vector to the goal.
   logic signed [33:0] dx, dy;
   vec_side_type vside_in, vside_out;
   assign dx = 34'(origin_x_ff) + 34'(goal_x_ff) - 34'(req_ch.pose_x);
   assign dy = 34'(origin_y_ff) + 34'(goal_y_ff) - 34'(req_ch.pose_y);
   assign vside_in.mode = req_ch.mode;
   assign vside_in.heading = req_ch.pose_heading;

   logic vec_valid;
   logic [35:0] vec_r;
   logic signed [17:0] vec_ang;

   gtp_vec_cordic #(.STAGES(NST)) u_vec (
      .clock(clock), .reset(reset), .en(en), .in_valid(accept),
      .dx(dx), .dy(dy), .side_in(vside_in),
      .out_valid(vec_valid), .r(vec_r), .ang(vec_ang), .side_out(vside_out)
   );

   logic law_valid;
   logic signed [15:0] law_speed, law_alpha;
   rot_side_type law_side, rot_side;

   gtp_law #(
      .GAIN_DISTANCE_SIMPLE(GAIN_DISTANCE_SIMPLE), .GAIN_ALPHA(GAIN_ALPHA),
      .GAIN_DISTANCE_POLAR(GAIN_DISTANCE_POLAR), .GAIN_BETA(GAIN_BETA)
   ) u_law (
      .clock(clock), .reset(reset), .en(en), .in_valid(vec_valid),
      .r(vec_r), .ang(vec_ang), .side_in(vside_out), .cfg(cfg_ff),
      .out_valid(law_valid), .speed(law_speed), .alpha_rot(law_alpha),
      .side_out(law_side)
   );

   logic rot_valid;
   logic signed [15:0] rot_vx, rot_vy;

   gtp_rot_cordic #(.STAGES(NST)) u_rot (
      .clock(clock), .reset(reset), .en(en), .in_valid(law_valid),
      .speed(law_speed), .alpha(law_alpha), .side_in(law_side),
      .out_valid(rot_valid), .vx(rot_vx), .vy(rot_vy), .side_out(rot_side)
   );

   // Final result selection.
   logic push;
   logic signed [15:0] fin_vx, fin_vy;
   assign push = rot_valid && en;
   assign fin_vx = rot_side.use_rot ? rot_vx : rot_side.vx_plain;
   assign fin_vy = rot_side.use_rot ? rot_vy : 16'sd0;

   // Output register with one skid slot.
   logic signed [15:0] out_vx_ff, out_vy_ff, out_w_ff, skid_vx_ff, skid_vy_ff, skid_w_ff;
   logic [1:0] out_st_ff, skid_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ch.ready) begin
         rsp_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_vx_ff <= skid_vx_ff;
            out_vy_ff <= skid_vy_ff;
            out_w_ff <= skid_w_ff;
            out_st_ff <= skid_st_ff;
         end else begin
            out_vx_ff <= fin_vx;
            out_vy_ff <= fin_vy;
            out_w_ff <= rot_side.turn;
            out_st_ff <= rot_side.status;
         end
      end else if (push) begin
         skid_vx_ff <= fin_vx;
         skid_vy_ff <= fin_vy;
         skid_w_ff <= rot_side.turn;
         skid_st_ff <= rot_side.status;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.velocity_x = out_vx_ff;
   assign rsp_ch.velocity_y = out_vy_ff;
   assign rsp_ch.turn_rate = out_w_ff;
   assign rsp_ch.status = out_st_ff;

   // The skid slot only fills behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff) else $error("skid full without output");

   // Requests are refused only while the skid slot is occupied.
   a_ready_skid: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> skid_valid_ff) else $error("ready low with empty skid");

   // Any result that is not a running command carries zero velocities.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_st_ff != ST_RUN)) |->
      (out_vx_ff == 16'sd0 && out_vy_ff == 16'sd0 && out_w_ff == 16'sd0))
      else $error("nonzero command outside running status");

   // A relative start captures the pose as origin.
   a_origin_capture: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.mode == MODE_START && cfg_ff.flags[FLAG_REL]) |=>
      (origin_x_ff == $past(req_ch.pose_x) && origin_y_ff == $past(req_ch.pose_y)))
      else $error("origin not captured");

endmodule
